### rtl/core/mms_pkg.sv
// mms_pkg: shared constants and types of the min/max stack unit.
// No dependencies; used by min_max_stack_unit.
package mms_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int FIELD_BITS     = 32;
	localparam int COUNT_BITS     = 7;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_LOAD
	} fsm_t;

endpackage

### rtl/core/min_max_stack_unit.sv
// min_max_stack_unit: LIFO stack of signed values reporting min and max.
// Depends on mms_pkg and mms_ram (value stack and extremes ring).
//
// Usage:
//   Command word in: mode/value, taken at a rising edge with start high and
//   busy low. mode = push value or pop top.
//   Result word out: top_value, min_value, max_value, item_count and status,
//   shown for exactly one cycle with done high. The receiver cannot stall.
// Timing: after acceptance the sequencer enters FSM_LOAD; done and the
//   result word are registered as it leaves that state.
// Sequence: in the accepting cycle the unit compares against the
//   cached top/min/max registers, decides the operation, writes the two RAMs
//   and issues the refill reads; in FSM_LOAD it takes the registered RAM
//   read data into the caches. busy is high in FSM_LOAD only, so no new
//   command is taken while the last one refills; the next command may be
//   accepted in the cycle that the previous result is on the ports.
// Status: ST_FULL when a push finds the stack full (dropped), ST_EMPTY when
//   a pop finds it empty (no change). When empty, all values read as zero.
// Reset: arst_n clears counts, ring indices and the sequencer. The RAMs are
//   not cleared; only entries below the counts are ever used.
module min_max_stack_unit #(
	parameter int DEPTH      = mms_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = mms_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               mode,
	input  logic signed [mms_pkg::FIELD_BITS-1:0] value,
	output logic                               done,
	output logic signed [mms_pkg::FIELD_BITS-1:0] top_value,
	output logic signed [mms_pkg::FIELD_BITS-1:0] min_value,
	output logic signed [mms_pkg::FIELD_BITS-1:0] max_value,
	output logic [mms_pkg::COUNT_BITS-1:0]     item_count,
	output logic [1:0]                         status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int FB = mms_pkg::FIELD_BITS;

	// ring index step with wrap at DEPTH (DEPTH need not be a power of two)
	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
	endfunction

	// sequencer
	mms_pkg::fsm_t state_q, state_d;
	logic          accept;

	// architectural state; ring entries are cached at both ends
	logic [CW-1:0]                cnt_q, ext_cnt_q;
	logic [AW-1:0]                front_q, back_q;
	logic signed [VALUE_BITS-1:0] top_q, min_q, max_q;

	// refill bookkeeping between acceptance and FSM_LOAD of one command
	logic             refill_top_s1, refill_min_s1, refill_max_s1;
	mms_pkg::status_t status_s1;

	// result word
	logic                        done_q;
	logic signed [FB-1:0]        top_value_q, min_value_q, max_value_q;
	logic [mms_pkg::COUNT_BITS-1:0] item_count_q;
	mms_pkg::status_t            status_q;

	// RAM ports
	logic                  stk_we, ext_we;
	logic [AW-1:0]         stk_waddr, ext_waddr, stk_raddr, ext_raddr;
	logic [VALUE_BITS-1:0] stk_rdata, ext_rdata;

	// decode of the incoming command
	logic signed [VALUE_BITS-1:0] v;
	logic                         is_push, push_ok, pop_ok;
	logic                         to_back, to_front, del_back, del_front;
	logic [CW-1:0]                cnt_m2;

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		accept  = 1'b0;
		unique case (state_q)
			mms_pkg::FSM_IDLE: begin
				accept = start;
				if (start) begin
					state_d = mms_pkg::FSM_LOAD;
				end
			end
			mms_pkg::FSM_LOAD: begin
				busy    = 1'b1;
				state_d = mms_pkg::FSM_IDLE;
			end
			default: begin
				state_d = mms_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mms_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		v         = VALUE_BITS'(value);
		is_push   = (mode == mms_pkg::MODE_PUSH);
		push_ok   = is_push && (cnt_q != CW'(DEPTH));
		pop_ok    = !is_push && (cnt_q != '0);
		// ring never outgrows the stack, so it has room whenever the stack does
		to_back   = push_ok && ((ext_cnt_q == '0) || (v <= min_q));
		to_front  = push_ok && !to_back && (v >= max_q);
		del_back  = pop_ok && (ext_cnt_q != '0) && (top_q == min_q);
		del_front = pop_ok && (ext_cnt_q != '0) && !del_back && (top_q == max_q);
		cnt_m2    = cnt_q - CW'(2);

		stk_we    = accept && push_ok;
		stk_waddr = cnt_q[AW-1:0];
		stk_raddr = cnt_m2[AW-1:0];   // next top after a pop; unused if it empties

		ext_we    = accept && (to_back || to_front);
		ext_waddr = to_back ? back_q : ring_dec(front_q);
		ext_raddr = del_back ? ring_dec(ring_dec(back_q)) : ring_inc(front_q);
	end

	mms_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(v),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	mms_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_ext_ram (
		.clk  (clk),
		.we   (ext_we),
		.waddr(ext_waddr),
		.wdata(v),
		.raddr(ext_raddr),
		.rdata(ext_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			ext_cnt_q     <= '0;
			front_q       <= '0;
			back_q        <= '0;
			refill_top_s1 <= 1'b0;
			refill_min_s1 <= 1'b0;
			refill_max_s1 <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q <= (state_q == mms_pkg::FSM_LOAD);
			if (accept) begin
				refill_top_s1 <= pop_ok;
				refill_min_s1 <= del_back;
				refill_max_s1 <= del_front;
				if (push_ok) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (pop_ok) begin
					cnt_q <= cnt_q - CW'(1);
				end
				if (to_back || to_front) begin
					ext_cnt_q <= ext_cnt_q + CW'(1);
				end else if (del_back || del_front) begin
					ext_cnt_q <= ext_cnt_q - CW'(1);
				end
				if (to_back) begin
					back_q <= ring_inc(back_q);
				end else if (del_back) begin
					back_q <= ring_dec(back_q);
				end
				if (to_front) begin
					front_q <= ring_dec(front_q);
				end else if (del_front) begin
					front_q <= ring_inc(front_q);
				end
			end
		end
	end

	// cached ends and result word
	logic signed [VALUE_BITS-1:0] top_n, min_n, max_n;

	always_comb begin
		top_n = refill_top_s1 ? $signed(stk_rdata) : top_q;
		min_n = refill_min_s1 ? $signed(ext_rdata) : min_q;
		max_n = refill_max_s1 ? $signed(ext_rdata) : max_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= push_ok || pop_ok ? mms_pkg::ST_OK :
			             is_push ? mms_pkg::ST_FULL : mms_pkg::ST_EMPTY;
			if (push_ok) begin
				top_q <= v;
			end
			if (to_back) begin
				min_q <= v;
				if (ext_cnt_q == '0) begin
					max_q <= v;
				end
			end
			if (to_front) begin
				max_q <= v;
			end
		end
		if (state_q == mms_pkg::FSM_LOAD) begin
			top_q        <= top_n;
			min_q        <= min_n;
			max_q        <= max_n;
			top_value_q  <= (cnt_q != '0) ? FB'(top_n) : '0;
			min_value_q  <= (cnt_q != '0 && ext_cnt_q != '0) ? FB'(min_n) : '0;
			max_value_q  <= (cnt_q != '0 && ext_cnt_q != '0) ? FB'(max_n) : '0;
			item_count_q <= mms_pkg::COUNT_BITS'(cnt_q);
			status_q     <= status_s1;
		end
	end

	assign done       = done_q;
	assign top_value  = top_value_q;
	assign min_value  = min_value_q;
	assign max_value  = max_value_q;
	assign item_count = item_count_q;
	assign status     = status_q;

endmodule

### rtl/core/mms_ram.sv
// mms_ram: generic single-clock RAM, one write port and one read port,
// registered read data. No dependencies.
module mms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### test/min_max_stack_checker.sv
// min_max_stack_checker: watches the command and result words of the min/max stack,
// predicts each result and compares it field by field.
// Depends on mms_pkg for widths, mode codes and status_t.
module min_max_stack_checker
	import mms_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         mode,
	input  logic signed [FIELD_BITS-1:0] value,
	input  logic                         done,
	input  logic signed [FIELD_BITS-1:0] top_value,
	input  logic signed [FIELD_BITS-1:0] min_value,
	input  logic signed [FIELD_BITS-1:0] max_value,
	input  logic [COUNT_BITS-1:0]        item_count,
	input  logic [1:0]                   status,
	output int                           mismatches,
	output int                           words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_BITS  = $clog2(DEPTH_DEF);
	localparam int EXP_SLOTS = 8;

	typedef struct {
		logic signed [FIELD_BITS-1:0] top;
		logic signed [FIELD_BITS-1:0] lo;
		logic signed [FIELD_BITS-1:0] hi;
		logic [COUNT_BITS-1:0]        count;
		status_t                      st;
	} stack_result_t;

	// model state: value stack plus ring of extremes (back = min end, front = max end)
	logic signed [FIELD_BITS-1:0] stack_mem [DEPTH_DEF];
	logic signed [FIELD_BITS-1:0] extreme_ring [DEPTH_DEF];
	logic [COUNT_BITS-1:0]        stack_cnt;
	logic [COUNT_BITS-1:0]        extreme_cnt;
	logic [IDX_BITS-1:0]          front_idx;
	logic [IDX_BITS-1:0]          back_idx;

	// expected result words in order of acceptance, as a small circular buffer
	stack_result_t expected_results [EXP_SLOTS];
	int            exp_head;
	int            exp_tail;

	initial mismatches = 0;
	initial words_pending = 0;

	task automatic report_mismatch(input string field, input logic [31:0] seen,
			input logic [31:0] wanted);
		$display("ERROR %0t ns: %s got %0h want %0h", $realtime, field, seen, wanted);
		mismatches++;
	endtask

	function automatic stack_result_t apply_stack_op(input logic op,
			input logic signed [FIELD_BITS-1:0] v);
		stack_result_t                r;
		logic signed [FIELD_BITS-1:0] back_v;
		logic signed [FIELD_BITS-1:0] front_v;
		logic signed [FIELD_BITS-1:0] top_v;
		r.st = ST_OK;
		back_v = extreme_ring[back_idx - 1'b1];
		front_v = extreme_ring[front_idx];
		if (op == MODE_PUSH) begin
			if (stack_cnt >= DEPTH_DEF) begin
				r.st = ST_FULL;
			end else begin
				stack_mem[stack_cnt] = v;
				stack_cnt++;
				if (extreme_cnt < DEPTH_DEF) begin
					if (extreme_cnt == 0 || v <= back_v) begin
						extreme_ring[back_idx] = v;
						back_idx++;
						extreme_cnt++;
					end else if (v >= front_v) begin
						front_idx--;
						extreme_ring[front_idx] = v;
						extreme_cnt++;
					end
				end
			end
		end else begin
			if (stack_cnt == 0) begin
				r.st = ST_EMPTY;
			end else begin
				top_v = stack_mem[stack_cnt - 1'b1];
				if (extreme_cnt > 0) begin
					if (top_v == back_v) begin
						back_idx--;
						extreme_cnt--;
					end else if (top_v == front_v) begin
						front_idx++;
						extreme_cnt--;
					end
				end
				stack_cnt--;
			end
		end
		r.top = (stack_cnt > 0) ? stack_mem[stack_cnt - 1'b1] : '0;
		if (stack_cnt > 0 && extreme_cnt > 0) begin
			r.lo = extreme_ring[back_idx - 1'b1];
			r.hi = extreme_ring[front_idx];
		end else begin
			r.lo = '0;
			r.hi = '0;
		end
		r.count = stack_cnt;
		return r;
	endfunction

	// inputs and outputs change by NBA at the edge, so values seen here are pre-edge
	always @(posedge clk or negedge arst_n) begin
		stack_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH_DEF; i++) begin
				stack_mem[i] = '0;
				extreme_ring[i] = '0;
			end
			stack_cnt = '0;
			extreme_cnt = '0;
			front_idx = '0;
			back_idx = '0;
			exp_head = 0;
			exp_tail = 0;
		end else begin
			if (done) begin
				if (exp_tail == exp_head) begin
					report_mismatch("result word with none expected", 32'h0, 32'h0);
				end else begin
					want = expected_results[exp_head % EXP_SLOTS];
					exp_head++;
					if (top_value !== want.top)
						report_mismatch("top_value", top_value, want.top);
					if (min_value !== want.lo)
						report_mismatch("min_value", min_value, want.lo);
					if (max_value !== want.hi)
						report_mismatch("max_value", max_value, want.hi);
					if (item_count !== want.count)
						report_mismatch("item_count", 32'(item_count), 32'(want.count));
					if (status !== want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
				end
			end
			if (start && !busy) begin
				expected_results[exp_tail % EXP_SLOTS] = apply_stack_op(mode, value);
				exp_tail++;
			end
		end
		words_pending = exp_tail - exp_head;
	end

endmodule

### test/tb.sv
// tb: top of the min/max stack testbench; drives command words and gives the verdict.
// Depends on mms_pkg, min_max_stack_unit and min_max_stack_checker.
module tb;
	import mms_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_WORDS = 1650;
	localparam int PHASE_WORDS = 550;  // length of each idling phase

	logic                         clk    = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start  = 1'b0;
	logic                         mode   = MODE_PUSH;
	logic signed [FIELD_BITS-1:0] value  = '0;

	logic                         busy;
	logic                         done;
	logic signed [FIELD_BITS-1:0] top_value;
	logic signed [FIELD_BITS-1:0] min_value;
	logic signed [FIELD_BITS-1:0] max_value;
	logic [COUNT_BITS-1:0]        item_count;
	logic [1:0]                   status;

	int mismatches;
	int words_pending;
	int words_sent = 0;

	always #2 clk = ~clk;

	min_max_stack_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.value      (value),
		.done       (done),
		.top_value  (top_value),
		.min_value  (min_value),
		.max_value  (max_value),
		.item_count (item_count),
		.status     (status)
	);

	// the checker sits on both channels; the top only feeds stimulus
	min_max_stack_checker watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.value         (value),
		.done          (done),
		.top_value     (top_value),
		.min_value     (min_value),
		.max_value     (max_value),
		.item_count    (item_count),
		.status        (status),
		.mismatches    (mismatches),
		.words_pending (words_pending)
	);

	// hard stop; a healthy run takes well under a tenth of this
	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

	// Send one command word. Called just after a rising edge and returns just
	// after the edge that took the word, with start still high so that
	// back-to-back words need no extra assignment in that step.
	// Sender idling: 27% in the first phase, 85% in the second, none after.
	task automatic issue_word(input logic op, input logic signed [FIELD_BITS-1:0] v);
		int idle_pct;
		idle_pct = (words_sent < PHASE_WORDS) ? 27 :
			(words_sent < 2 * PHASE_WORDS) ? 85 : 0;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode  <= op;
		value <= v;
		// busy only follows the internal sequencer, so it is settled mid-cycle
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		words_sent++;
	endtask

	// Narrow values in 40% of picks so that ties with the stored min/max are common,
	// with the two's complement extremes mixed in and full-width noise in half of them.
	function automatic logic signed [FIELD_BITS-1:0] pick_value();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			1, 2, 3: return $signed($urandom_range(15)) - 32'sd8;
			4: return $signed($urandom_range(2000)) - 32'sd1000;
			default: return $signed($urandom);
		endcase
	endfunction

	initial begin
		int run_len;
		int push_pct;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: underflow on empty, signed extremes, ties at both ends,
		// a value that lands between min and max and is not tracked,
		// then unwind to empty and underflow once more
		issue_word(MODE_POP,  32'sd0);
		issue_word(MODE_PUSH, 32'sh7fff_ffff);
		issue_word(MODE_PUSH, 32'sh8000_0000);
		issue_word(MODE_PUSH, 32'sd0);
		issue_word(MODE_PUSH, -32'sd1);
		issue_word(MODE_PUSH, 32'sh8000_0000);
		issue_word(MODE_PUSH, 32'sh7fff_ffff);
		issue_word(MODE_PUSH, 32'sd5);
		issue_word(MODE_PUSH, 32'sd5);
		repeat (8)
			issue_word(MODE_POP, $signed($urandom));
		issue_word(MODE_POP,  32'sh7fff_ffff);
		issue_word(MODE_PUSH, -32'sd7);
		issue_word(MODE_POP,  32'sd0);

		// random runs with a push bias per run: the heavy-push runs fill the
		// 64-entry stack and hit overflow, the light ones drain it to underflow
		while (words_sent < TOTAL_WORDS) begin
			run_len = $urandom_range(20, 120);
			case ($urandom_range(4))
				0: push_pct = 15;
				1: push_pct = 50;
				2: push_pct = 70;
				3: push_pct = 90;
				default: push_pct = 100;
			endcase
			for (int i = 0; i < run_len && words_sent < TOTAL_WORDS; i++)
				issue_word(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP,
					pick_value());
		end
		start <= 1'b0;

		// drain: wait until the checker has no result words pending
		do
			@(negedge clk);
		while (words_pending != 0);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
rtl/core/mms_pkg.sv
rtl/core/mms_ram.sv
rtl/core/min_max_stack_unit.sv
test/min_max_stack_checker.sv
test/tb.sv
